>>> hdl/ptshf_pkg.sv
// Shared types and constants for the per-thread state hysteresis filter.
package ptshf_pkg;

    localparam int unsigned TableEntriesDefault = 1024;
    localparam logic [31:0] MinDurationReset = 32'd100000;

    localparam logic [7:0] CodeReady     = 8'd1;
    localparam logic [7:0] CodeResumed   = 8'd2;
    localparam logic [7:0] CodeSuspended = 8'd3;

    localparam logic [1:0] StRunning   = 2'd0;
    localparam logic [1:0] StStalled   = 2'd1;
    localparam logic [1:0] StSuspended = 2'd2;

    localparam logic [0:0] RegMinDuration = 1'd0;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CMP   = 6'b000100,
        S_GAP   = 6'b001000,
        S_WRITE = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

endpackage

>>> hdl/ptshf_table.sv
// Key, state and timestamp memory of the thread table, one read and one write port.
module ptshf_table #(
    parameter int unsigned TABLE_ENTRIES = ptshf_pkg::TableEntriesDefault,
    localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic            aclk,
    input  logic [IdxW-1:0] rd_idx,
    output logic [63:0]     rd_key,
    output logic [1:0]      rd_state,
    output logic [63:0]     rd_time,
    input  logic            wr_en,
    input  logic [IdxW-1:0] wr_idx,
    input  logic [63:0]     wr_key,
    input  logic [1:0]      wr_state,
    input  logic [63:0]     wr_time
);

    logic [129:0] mem [TABLE_ENTRIES];
    logic [129:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= {wr_key, wr_state, wr_time};
        end
        rd_reg <= mem[rd_idx];
    end

    assign rd_key   = rd_reg[129:66];
    assign rd_state = rd_reg[65:64];
    assign rd_time  = rd_reg[63:0];

endmodule

>>> hdl/per_thread_state_hysteresis_filter.sv
// Top level of the per-thread lock-state hysteresis filter.
// A request scans the filled entries one by one, each through a read and a compare step,
// until its key matches or the fill count is reached.
// One request at a time; s_tready is high only in idle with the result register empty.
// Reset: synchronous, active low; clears fill count, sequencer and output valid, loads
// min_duration_ns with 100000.
module per_thread_state_hysteresis_filter #(
    parameter int unsigned TABLE_ENTRIES = ptshf_pkg::TableEntriesDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    // tdata: event_code[7:0], process_id[39:8], tid[71:40], time_ns[135:72],
    //        thread_handle[199:136]
    input  logic [199:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: out_process_id[31:0], out_thread_id[63:32], lock_state[65:64],
    //        out_time_ns[129:66], out_thread_handle[193:130], zero pad to 199
    output logic [199:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

    // Configuration register, at byte address zero.
    logic [31:0] min_dur_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[1] == ptshf_pkg::RegMinDuration) ? min_dur_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dur_reg <= ptshf_pkg::MinDurationReset;
        end else if (psel && penable && pwrite && pready
                     && paddr[1] == ptshf_pkg::RegMinDuration) begin
            min_dur_reg <= pwdata;
        end
    end

    // Captured request fields.
    logic [63:0] key_reg;
    logic [1:0]  st_reg;
    logic [63:0] time_reg;
    logic [63:0] handle_reg;

    ptshf_pkg::state_t state_reg, state_next;
    logic [CntW-1:0]   used_reg;
    logic [CntW-1:0]   scan_reg;
    logic              hit_reg;
    logic              emit_reg;
    logic [64:0]       diff_reg;
    logic [199:0]      out_reg;
    logic              out_vld_reg;

    logic [63:0] rd_key, rd_time;
    logic [1:0]  rd_state;
    logic        wr_en;
    logic [IdxW-1:0] wr_idx, rd_idx;

    assign rd_idx = scan_reg[IdxW-1:0];
    assign wr_idx = hit_reg ? scan_reg[IdxW-1:0] : used_reg[IdxW-1:0];
    assign wr_en  = (state_reg == ptshf_pkg::S_WRITE)
                    && (hit_reg || used_reg < CntW'(TABLE_ENTRIES));

    ptshf_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
        .aclk     (aclk),
        .rd_idx   (rd_idx),
        .rd_key   (rd_key),
        .rd_state (rd_state),
        .rd_time  (rd_time),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_key   (key_reg),
        .wr_state (st_reg),
        .wr_time  (time_reg)
    );

    // Code decode; unknown codes are dropped on acceptance.
    logic       code_ok;
    logic [1:0] code_st;
    always_comb begin
        code_ok = 1'b1;
        code_st = ptshf_pkg::StRunning;
        priority if (s_tdata[7:0] == ptshf_pkg::CodeReady) begin
            code_st = ptshf_pkg::StStalled;
        end else if (s_tdata[7:0] == ptshf_pkg::CodeResumed) begin
            code_st = ptshf_pkg::StRunning;
        end else if (s_tdata[7:0] == ptshf_pkg::CodeSuspended) begin
            code_st = ptshf_pkg::StSuspended;
        end else begin
            code_ok = 1'b0;
        end
    end

    // The block is ready in idle once the previous result has left the register.
    assign s_tready = (state_reg == ptshf_pkg::S_IDLE) && !out_vld_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptshf_pkg::S_IDLE: begin
                if (s_tvalid && s_tready && code_ok) begin
                    state_next = ptshf_pkg::S_READ;
                end
            end
            // Scan pointer is valid; wait for the registered read, or stop at the fill count.
            ptshf_pkg::S_READ:  state_next = (scan_reg == used_reg) ? ptshf_pkg::S_WRITE
                                                                    : ptshf_pkg::S_CMP;
            ptshf_pkg::S_CMP: begin
                if (rd_key == key_reg) begin
                    state_next = (rd_state == st_reg) ? ptshf_pkg::S_IDLE : ptshf_pkg::S_GAP;
                end else begin
                    state_next = ptshf_pkg::S_READ;
                end
            end
            ptshf_pkg::S_GAP:   state_next = ptshf_pkg::S_WRITE;
            ptshf_pkg::S_WRITE: state_next = ptshf_pkg::S_OUT;
            ptshf_pkg::S_OUT:   state_next = ptshf_pkg::S_IDLE;
            default:            state_next = ptshf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ptshf_pkg::S_IDLE;
            used_reg    <= '0;
            scan_reg    <= '0;
            hit_reg     <= 1'b0;
            emit_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                ptshf_pkg::S_IDLE: begin
                    scan_reg <= '0;
                    hit_reg  <= 1'b0;
                    emit_reg <= 1'b1;
                end
                ptshf_pkg::S_READ: ;
                ptshf_pkg::S_CMP: begin
                    if (rd_key == key_reg) begin
                        hit_reg <= 1'b1;
                    end else begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                ptshf_pkg::S_GAP: begin
                    // Backward time gives a negative difference, counted as a zero duration.
                    emit_reg <= diff_reg[64] ? (min_dur_reg == 32'd0)
                                             : (diff_reg[63:0] >= {32'd0, min_dur_reg});
                end
                ptshf_pkg::S_WRITE: begin
                    if (!hit_reg && used_reg < CntW'(TABLE_ENTRIES)) begin
                        used_reg <= used_reg + 1'b1;
                    end
                end
                ptshf_pkg::S_OUT: begin
                    out_vld_reg <= emit_reg;
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            key_reg    <= s_tdata[71:8];
            st_reg     <= code_st;
            time_reg   <= s_tdata[135:72];
            handle_reg <= s_tdata[199:136];
        end
        if (state_reg == ptshf_pkg::S_CMP) begin
            diff_reg <= {1'b0, time_reg} - {1'b0, rd_time};
        end
        if (state_reg == ptshf_pkg::S_OUT) begin
            out_reg <= {6'd0, handle_reg, time_reg, st_reg, key_reg[63:32], key_reg[31:0]};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // The fill count never passes the table size.
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CntW'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    // The scan never runs past the filled entries.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_reg <= used_reg)
        else $error("scan beyond filled entries");

    // No input is taken while a result waits.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("ready while result pending");

    // A result only appears right after the output step.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ptshf_pkg::S_OUT))
        else $error("result without output step");

endmodule

>>> dv/ptshf_checker.sv
// Scoreboard for the lock-state filter: predicts each transition report and compares.
`timescale 1ns / 100ps
module ptshf_checker #(
    parameter int unsigned TABLE_ENTRIES = ptshf_pkg::TableEntriesDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [199:0] s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [199:0] m_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           fail_count,
    output int           pending_reports
);

    // Packed from the top bit down, so pid lands in the lowest bits as on m_tdata.
    typedef struct packed {
        logic [63:0] handle;
        logic [63:0] ts;
        logic [1:0]  st;
        logic [31:0] tid;
        logic [31:0] pid;
    } report_t;

    logic [63:0] thread_key [TABLE_ENTRIES];
    logic [1:0]  thread_state [TABLE_ENTRIES];
    logic [63:0] thread_time [TABLE_ENTRIES];
    int unsigned threads_known;
    logic [31:0] hold_ns;
    report_t     expected_reports [$];

    assign pending_reports = expected_reports.size();

    // Applies one lock event to the shadow table; returns 1 with a report when one is due.
    function automatic bit filter_event(input logic [199:0] d, output report_t r);
        logic [7:0]  code;
        logic [63:0] key;
        logic [63:0] gap;
        logic [1:0]  st;
        int          hit;
        code = d[7:0];
        key = {d[39:8], d[71:40]};
        r.pid = d[39:8];
        r.tid = d[71:40];
        r.ts = d[135:72];
        r.handle = d[199:136];
        case (code)
            ptshf_pkg::CodeReady:     st = ptshf_pkg::StStalled;
            ptshf_pkg::CodeResumed:   st = ptshf_pkg::StRunning;
            ptshf_pkg::CodeSuspended: st = ptshf_pkg::StSuspended;
            default:                  return 0;
        endcase
        r.st = st;
        hit = -1;
        for (int i = 0; i < threads_known; i++) begin
            if (hit < 0 && thread_key[i] == key) hit = i;
        end
        if (hit >= 0) begin
            if (thread_state[hit] == st) return 0;
            gap = (r.ts > thread_time[hit]) ? r.ts - thread_time[hit] : 64'd0;
            thread_state[hit] = st;
            thread_time[hit] = r.ts;
            if (gap < {32'd0, hold_ns}) return 0;
        end else if (threads_known < TABLE_ENTRIES) begin
            thread_key[threads_known] = key;
            thread_state[threads_known] = st;
            thread_time[threads_known] = r.ts;
            threads_known++;
        end
        return 1;
    endfunction

    always @(posedge aclk) begin
        report_t r;
        report_t e;
        if (!aresetn) begin
            threads_known <= 0;
            hold_ns <= ptshf_pkg::MinDurationReset;
            fail_count <= 0;
            expected_reports.delete();
        end else begin
            if (psel && penable && pwrite && paddr[1] == ptshf_pkg::RegMinDuration)
                hold_ns <= pwdata;
            if (s_tvalid && s_tready && filter_event(s_tdata, r)) expected_reports.push_back(r);
            if (m_tvalid && m_tready) begin
                r = m_tdata[193:0];
                if (expected_reports.size() == 0) begin
                    $error("unexpected report pid=%h tid=%h", r.pid, r.tid);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_reports.pop_front();
                    if (r != e || m_tdata[199:194] != 0) begin
                        if (r.pid != e.pid)
                            $error("out_process_id exp %h got %h", e.pid, r.pid);
                        if (r.tid != e.tid)
                            $error("out_thread_id exp %h got %h", e.tid, r.tid);
                        if (r.st != e.st) $error("lock_state exp %0d got %0d", e.st, r.st);
                        if (r.ts != e.ts) $error("out_time_ns exp %h got %h", e.ts, r.ts);
                        if (r.handle != e.handle)
                            $error("out_thread_handle exp %h got %h", e.handle, r.handle);
                        if (m_tdata[199:194] != 0)
                            $error("pad exp 0 got %h", m_tdata[199:194]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> dv/tb_per_thread_state_hysteresis_filter.sv
// Testbench top: drives lock events and register writes, and reports the verdict.
`timescale 1ns / 100ps
module tb_per_thread_state_hysteresis_filter;

    // A small table keeps scans short and lets the full-table case happen early.
    localparam int unsigned Entries = 24;

    logic         aclk;
    logic         aresetn;
    logic [199:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         psel, penable, pwrite;
    logic [1:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending_reports;
    bit           calm;      // no idling in the last part of the run

    // Shadow of thread identities and one shared running clock, so that events on
    // known threads form plausible timelines.
    logic [31:0]  pid_pool [16];
    logic [31:0]  tid_pool [16];
    logic [63:0]  clock_ns;

    per_thread_state_hysteresis_filter #(.TABLE_ENTRIES(Entries)) dut (.*);

    ptshf_checker #(.TABLE_ENTRIES(Entries)) checker_i (
        .aclk, .aresetn, .s_tdata, .s_tvalid, .s_tready, .m_tdata, .m_tvalid, .m_tready,
        .psel, .penable, .pwrite, .paddr, .pwdata, .fail_count, .pending_reports
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("tb_per_thread_state_hysteresis_filter NOT OK");
        $finish;
    end

    // The receiver stalls in random bursts until the calm phase.
    always @(posedge aclk) begin
        int stall;
        if (!aresetn) begin
            m_tready <= 1'b1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 14);
            m_tready <= 1'b0;
            repeat (stall) @(posedge aclk);
            m_tready <= 1'b1;
        end
    end

    // Presents one request and holds it until the block accepts it. The valid stays
    // high afterwards so that the next request can follow at once; idling drops it.
    task automatic send_event(input logic [7:0] code, input logic [31:0] pid,
                              input logic [31:0] tid, input logic [63:0] ts,
                              input logic [63:0] handle);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {handle, ts, tid, pid, code};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Writes the register once every pending report is out and the block is idle.
    task automatic write_min_duration(input logic [31:0] value);
        s_tvalid <= 1'b0;
        while (pending_reports != 0) @(posedge aclk);
        repeat (2 * Entries + 10) @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {ptshf_pkg::RegMinDuration, 1'b0};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic random_events(input int count);
        logic [7:0]  code;
        logic [31:0] pid, tid;
        int          k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 15);
            pid = pid_pool[k];
            tid = tid_pool[k];
            code = 8'($urandom_range(1, 3));
            case ($urandom_range(0, 9))
                0: code = 8'($urandom);                     // mostly ignored codes
                1: begin pid = $urandom; tid = $urandom; end // fresh threads
                2: clock_ns = clock_ns - 64'($urandom_range(0, 50000)); // time goes back
                default: clock_ns = clock_ns + 64'($urandom_range(0, 300000));
            endcase
            if ($urandom_range(0, 30) == 0) clock_ns = {$urandom, $urandom};
            send_event(code, pid, tid, clock_ns, {$urandom, $urandom});
        end
    endtask

    initial begin
        s_tdata = '0; s_tvalid = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        calm = 0;
        clock_ns = 64'd1000;
        aresetn = 0;
        for (int i = 0; i < 16; i++) begin
            pid_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
            tid_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes of keys and times, every code, ignored codes,
        // repeats, short and long holds, and a timestamp that runs backward.
        send_event(8'd0, 32'd0, 32'd0, 64'd0, 64'd0);
        send_event(8'hFF, '1, '1, '1, '1);
        send_event(ptshf_pkg::CodeReady, 32'd0, 32'd0, 64'd0, 64'd0);
        send_event(ptshf_pkg::CodeReady, 32'd0, 32'd0, 64'd5, 64'd1);
        send_event(ptshf_pkg::CodeResumed, 32'd0, 32'd0, 64'd99999, 64'd2);
        send_event(ptshf_pkg::CodeSuspended, 32'd0, 32'd0, 64'd199999, 64'd3);
        send_event(ptshf_pkg::CodeReady, 32'd0, 32'd0, 64'd100, 64'd4);
        send_event(ptshf_pkg::CodeSuspended, '1, '1, '1, '1);
        send_event(ptshf_pkg::CodeResumed, '1, '1, 64'd0, '1);
        send_event(ptshf_pkg::CodeReady, '1, '1, 64'd100000, 64'h5555_AAAA_5555_AAAA);
        send_event(ptshf_pkg::CodeResumed, 32'd0, '1, 64'h8000_0000_0000_0000,
                   64'hAAAA_5555_AAAA_5555);
        send_event(8'd4, 32'd0, '1, 64'd0, 64'd0);

        // Setting sweep, with the extremes among the settings.
        write_min_duration(32'd0);
        random_events(80);
        write_min_duration('1);
        random_events(80);
        write_min_duration(32'd150000);
        random_events(120);
        write_min_duration(32'd100000);
        random_events(60);
        calm = 1;
        random_events(60);
        s_tvalid <= 1'b0;

        while (pending_reports != 0) @(posedge aclk);
        repeat (2 * Entries + 20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_per_thread_state_hysteresis_filter OK");
        end else begin
            $display("tb_per_thread_state_hysteresis_filter NOT OK");
        end
        $finish;
    end

endmodule
